// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define TCR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define TCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/tcr_pkg.sv =====
// types, constants and lookup functions for the text cell renderer
`default_nettype none
package tcr_pkg;

	typedef enum logic [1:0] {
		OP_CELL   = 2'd0,
		OP_RASTER = 2'd1,
		OP_FONT   = 2'd2,
		OP_COLOUR = 2'd3
	} op_t;

	typedef struct packed {
		logic [7:0] chr;
		logic [7:0] attr;
	} cell_t;

	localparam int MapDepth = 256;
	localparam int MapAw    = 8;

	localparam logic [7:0] GLYPH_SPACE      = 8'd32;
	localparam logic [7:0] GLYPH_NUL        = 8'd0;
	localparam logic [7:0] GLYPH_BLANK      = 8'd255;
	localparam logic [7:0] GLYPH_LIGHT      = 8'd176;
	localparam logic [7:0] GLYPH_MEDIUM     = 8'd177;
	localparam logic [7:0] GLYPH_DARK       = 8'd178;
	localparam logic [7:0] GLYPH_FULL       = 8'd219;
	localparam logic [7:0] GLYPH_LOWER_HALF = 8'd220;
	localparam logic [7:0] GLYPH_UPPER_HALF = 8'd223;
	localparam logic [7:0] HIGH_NIBBLE      = 8'hf0;

	localparam logic [3:0] MODE_RESET = 4'd8;
	localparam int FLAG_DROP_DARK  = 0;
	localparam int FLAG_HALF_MED   = 1;
	localparam int FLAG_BRIGHT_MED = 3;

	// perceived intensity of each of the sixteen palette colors
	function automatic logic [3:0] luma(input logic [3:0] color);
		logic [3:0] l;
		case (color)
			4'd0:    l = 4'd0;
			4'd1:    l = 4'd1;
			4'd2:    l = 4'd6;
			4'd3:    l = 4'd7;
			4'd4:    l = 4'd3;
			4'd5:    l = 4'd4;
			4'd6:    l = 4'd9;
			4'd7:    l = 4'd10;
			4'd8:    l = 4'd1;
			4'd9:    l = 4'd2;
			4'd10:   l = 4'd9;
			4'd11:   l = 4'd10;
			4'd12:   l = 4'd5;
			4'd13:   l = 4'd6;
			4'd14:   l = 4'd13;
			default: l = 4'd15;
		endcase
		return l;
	endfunction

	function automatic logic [7:0] swap_nibbles(input logic [7:0] a);
		return {a[3:0], a[7:4]};
	endfunction

endpackage
`default_nettype wire

// ===== rtl/tcr_if.sv =====
// valid/ready channel interfaces: command, result and mode register write
`default_nettype none
interface tcr_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] cell_char;
	logic [7:0] cell_attr;
	logic [7:0] raster_upper;
	logic [7:0] raster_lower;
	logic [7:0] table_index;
	logic [7:0] table_value;

	modport source (output valid, opcode, cell_char, cell_attr, raster_upper,
		raster_lower, table_index, table_value, input ready);
	modport sink (input valid, opcode, cell_char, cell_attr, raster_upper,
		raster_lower, table_index, table_value, output ready);
endinterface

interface tcr_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic [7:0] out_attr;

	modport source (output valid, out_char, out_attr, input ready);
	modport sink (input valid, out_char, out_attr, output ready);
endinterface

interface tcr_cfg_if;
	logic       valid;
	logic       ready;
	logic [3:0] mode_flags;

	modport source (output valid, mode_flags, input ready);
	modport sink (input valid, mode_flags, output ready);
endinterface
`default_nettype wire

// ===== rtl/text_cell_renderer.sv =====
// top level of the text cell renderer: raster pick, normalize, font/color lookup
//
// channel  | role   | payload
// ---------+--------+--------------------------------------------------------
// cmd      | sink   | opcode, cell_char, cell_attr, raster_upper/lower, table_index/value
// result   | source | out_char, out_attr
// cfg      | sink   | mode_flags (always ready)
//
// one item per clock when result is not stalled; a cell or raster item is held in
// the s1 register, then read from the map memories into the registered stage 2
// output that is offered on result, map loads take one slot and give no result
// reset clears the pipeline valids, the map loaded bits and sets mode_flags to 8
// a stalled result holds stage 2 and the memory reads; an empty stage 1 still
// takes one item, then cmd.ready drops until result is taken
`default_nettype none
`include "assert_macros.svh"
module text_cell_renderer (
	input  wire logic    clk,
	input  wire logic    arst_n,
	tcr_cmd_if.sink      cmd,
	tcr_result_if.source result,
	tcr_cfg_if.sink      cfg
);
	import tcr_pkg::*;

	// mode register
	logic [3:0] mode_flags_q;

	// stage 1: decoded cell or map load
	logic       valid_s1;
	op_t        op_s1;
	cell_t      cell_s1;
	logic [7:0] idx_s1;
	logic [7:0] val_s1;

	// stage 2: registered map reads drive the result
	logic       valid_s2;

	cell_t      raster_cell;
	cell_t      in_cell;
	cell_t      norm_cell;
	op_t        cmd_op;
	logic       adv;
	logic       step_s1;
	logic       is_conv_s1;
	logic       font_wr, colour_wr;
	logic [7:0] font_addr, colour_addr;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_flags_q <= MODE_RESET;
		end else if (cfg.valid) begin
			mode_flags_q <= cfg.mode_flags;
		end
	end

	// pipeline moves whenever the result slot is empty or being taken
	assign adv       = !valid_s2 || result.ready;
	assign cmd.ready = adv || !valid_s1;
	assign cmd_op    = op_t'(cmd.opcode);

	tcr_raster u_raster (
		.upper  (cmd.raster_upper),
		.lower  (cmd.raster_lower),
		.cell_o (raster_cell)
	);

	always_comb begin
		if (cmd_op == OP_RASTER) begin
			in_cell = raster_cell;
		end else begin
			in_cell.chr  = cmd.cell_char;
			in_cell.attr = cmd.cell_attr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_s1   <= cmd_op;
			cell_s1 <= in_cell;
			idx_s1  <= cmd.table_index;
			val_s1  <= cmd.table_value;
		end
	end

	tcr_norm u_norm (
		.cell_i (cell_s1),
		.flags  (mode_flags_q),
		.cell_o (norm_cell)
	);

	// loads and lookups reach the maps in item order, so a load is seen by
	// every later lookup without forwarding
	assign step_s1    = valid_s1 && adv;
	assign is_conv_s1 = (op_s1 == OP_CELL) || (op_s1 == OP_RASTER);
	assign font_wr    = (op_s1 == OP_FONT);
	assign colour_wr  = (op_s1 == OP_COLOUR);
	assign font_addr  = font_wr ? idx_s1 : norm_cell.chr;
	assign colour_addr = colour_wr ? idx_s1 : norm_cell.attr;

	tcr_map u_font_map (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (step_s1 && !colour_wr),
		.wr     (font_wr),
		.addr   (font_addr),
		.wdata  (val_s1),
		.rdata  (result.out_char)
	);

	tcr_map u_colour_map (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (step_s1 && !font_wr),
		.wr     (colour_wr),
		.addr   (colour_addr),
		.wdata  (val_s1),
		.rdata  (result.out_attr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1 && is_conv_s1;
		end
	end

	assign result.valid = valid_s2;

	// a map load in stage 1 never turns into a result
	`TCR_ASSERT_NEXT(a_load_no_result, clk, arst_n, step_s1 && !is_conv_s1, !valid_s2,
		"map load produced a result")

	// a stalled stage 1 keeps its cell until the result side frees up
	`TCR_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !adv,
		valid_s1 && $stable(cell_s1) && $stable(op_s1), "stage 1 lost its item under stall")

	// stage 1 is never overwritten while it cannot move on
	`TCR_ASSERT_NOW(a_no_overrun, clk, arst_n, valid_s1 && !adv, !cmd.ready,
		"command taken while stage 1 is blocked")

endmodule
`default_nettype wire

// ===== rtl/tcr_raster.sv =====
// picks a half block or shade cell for an upper/lower color pair
`default_nettype none
module tcr_raster (
	input  wire logic [7:0]   upper,
	input  wire logic [7:0]   lower,
	output tcr_pkg::cell_t    cell_o
);
	import tcr_pkg::*;

	logic [5:0] uw, dw;

	// weight: low nibble plus three times high nibble
	assign uw = 6'(luma(upper[3:0])) + 6'(luma(upper[7:4])) * 6'd3;
	assign dw = 6'(luma(lower[3:0])) + 6'(luma(lower[7:4])) * 6'd3;

	always_comb begin
		if ({1'b0, uw} >= {dw, 1'b0}) begin
			cell_o.chr  = GLYPH_UPPER_HALF;
			cell_o.attr = {lower[7:4], upper[7:4]};
		end else if ({1'b0, dw} >= {uw, 1'b0}) begin
			cell_o.chr  = GLYPH_LOWER_HALF;
			cell_o.attr = {upper[7:4], lower[7:4]};
		end else begin
			cell_o.chr  = GLYPH_LIGHT;
			cell_o.attr = upper | lower;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/tcr_norm.sv =====
// cell normalization: collapse, flip, mode-driven medium substitution and glyph removal
`default_nettype none
module tcr_norm (
	input  wire tcr_pkg::cell_t cell_i,
	input  wire logic [3:0]   flags,
	output tcr_pkg::cell_t    cell_o
);
	import tcr_pkg::*;

	logic [7:0] ch, c, a;
	logic [3:0] fg, bg;

	assign ch = cell_i.chr;

	always_comb begin
		fg = cell_i.attr[3:0];
		bg = cell_i.attr[7:4];
		c  = ch;
		a  = cell_i.attr;

		if (ch == GLYPH_SPACE || ch == GLYPH_NUL || ch == GLYPH_BLANK) begin
			fg = bg;
		end else if (ch == GLYPH_FULL) begin
			bg = fg;
		end

		if (fg == bg) begin
			if (fg[3]) begin
				c = GLYPH_FULL;
				a = {4'd0, fg};
			end else begin
				c = GLYPH_SPACE;
				a = {fg, 4'd0};
			end
		end else if (ch >= GLYPH_LOWER_HALF && ch <= GLYPH_UPPER_HALF) begin
			if (a[7] && luma(bg) > luma(fg)) begin
				// upper and lower halves mirror by inverting the two low bits
				c = ch ^ 8'd3;
				a = swap_nibbles(a);
			end
			if (flags[FLAG_HALF_MED]) begin
				c = GLYPH_MEDIUM;
			end
		end else if (ch >= GLYPH_LIGHT && ch <= GLYPH_DARK) begin
			if (a[7] || luma(bg) > luma(fg)) begin
				if (ch == GLYPH_LIGHT) begin
					c = GLYPH_DARK;
				end else if (ch == GLYPH_DARK) begin
					c = GLYPH_LIGHT;
				end
				a = swap_nibbles(a);
				if (a[7] && flags[FLAG_BRIGHT_MED] && c == GLYPH_LIGHT) begin
					c = GLYPH_MEDIUM;
				end
			end
		end

		if ((c == GLYPH_DARK || c == GLYPH_FULL) && flags[FLAG_DROP_DARK]) begin
			c = (c == GLYPH_DARK) ? GLYPH_LIGHT : GLYPH_SPACE;
			a = swap_nibbles(a);
		end
	end

	assign cell_o.chr  = c;
	assign cell_o.attr = a;

endmodule
`default_nettype wire

// ===== rtl/tcr_map.sv =====
// 256-entry loadable byte map, identity until written, registered read
`default_nettype none
module tcr_map (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       wr,
	input  wire logic [tcr_pkg::MapAw-1:0]  addr,
	input  wire logic [7:0]                 wdata,
	output logic [7:0]                      rdata
);
	import tcr_pkg::*;

	logic [7:0]          mem [MapDepth];
	logic [MapDepth-1:0] loaded_q;
	logic [7:0]          raw_q;
	logic                hit_q;
	logic [MapAw-1:0]    addr_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (wr) begin
				mem[addr] <= wdata;
			end else begin
				raw_q  <= mem[addr];
				addr_q <= addr;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= '0;
			hit_q    <= 1'b0;
		end else if (en) begin
			if (wr) begin
				loaded_q[addr] <= 1'b1;
			end else begin
				hit_q <= loaded_q[addr];
			end
		end
	end

	// entries never loaded read back as their own index
	assign rdata = hit_q ? raw_q : addr_q;

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// self-checking testbench for the text cell renderer: random and directed cells, rasters, map loads
`timescale 1ns / 100ps
`default_nettype none
module testbench;
	import tcr_pkg::*;

	// one pending item for the driver: either a command or a mode register write
	typedef struct packed {
		logic       is_mode;
		logic [3:0] mode;
		op_t        op;
		logic [7:0] chr;
		logic [7:0] attr;
		logic [7:0] upper;
		logic [7:0] lower;
		logic [7:0] idx;
		logic [7:0] val;
	} stim_t;

	// cycles without traffic before the pipeline counts as drained
	localparam int SETTLE = 6;
	localparam int PHASE_ITEMS = 190;
	localparam int MAX_SHOWN = 10;

	// palette intensities, color 15 in the top nibble down to color 0 at the bottom
	localparam logic [63:0] INTENSITY_ROM = {
		4'd15, 4'd13, 4'd6, 4'd5, 4'd10, 4'd9, 4'd2, 4'd1,
		4'd10, 4'd9, 4'd4, 4'd3, 4'd7, 4'd6, 4'd1, 4'd0
	};

	logic clk;
	logic arst_n;

	tcr_cmd_if    cmd_ch ();
	tcr_result_if res_ch ();
	tcr_cfg_if    cfg_ch ();

	text_cell_renderer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	// shadow state of the block
	logic [7:0] font_tbl [256];
	logic [7:0] colour_tbl [256];
	logic [3:0] mode_reg;

	stim_t stim_q [$];
	cell_t cells_due [$];

	// handshake flags seen at the last rising edge, used by the falling-edge drivers
	bit cmd_taken;
	bit cfg_taken;
	int idle_cycles;
	int cmd_gap;
	int res_gap;

	// run statistics
	int n_accepted;
	int n_cells;
	int n_rasters;
	int n_loads;
	int n_modes;
	int n_checked;
	int errors;

	always #2 clk = ~clk;

	// ---------------------------------------------------------------
	// behavior of the block
	// ---------------------------------------------------------------

	function automatic logic [3:0] lum(input logic [3:0] color);
		return INTENSITY_ROM[{color, 2'b00} +: 4];
	endfunction

	// weighted brightness of a color pair, background counts three times
	function automatic int pair_weight(input logic [7:0] v);
		return int'(lum(v[3:0])) + 3 * int'(lum(v[7:4]));
	endfunction

	// normalize one cell and look it up in the font and color maps
	function automatic cell_t render_cell(input logic [7:0] ch, input logic [7:0] at);
		logic [3:0] fg;
		logic [3:0] bg;
		logic [7:0] c;
		logic [7:0] a;
		cell_t r;
		fg = at[3:0];
		bg = at[7:4];
		c = ch;
		a = at;
		// blank glyphs show only background, a full block only foreground
		if (ch == GLYPH_SPACE || ch == GLYPH_NUL || ch == GLYPH_BLANK) begin
			fg = bg;
		end else if (ch == GLYPH_FULL) begin
			bg = fg;
		end
		if (fg == bg) begin
			// one solid color: bright ones as a full block, dark ones as a space
			if (fg[3]) begin
				c = GLYPH_FULL;
				a = {4'd0, fg};
			end else begin
				c = GLYPH_SPACE;
				a = {fg, 4'd0};
			end
		end else if (ch >= GLYPH_LOWER_HALF && ch <= GLYPH_UPPER_HALF) begin
			// half blocks flip when the bright background is the stronger color
			if (a[7] && lum(bg) > lum(fg)) begin
				c = GLYPH_UPPER_HALF - (c - GLYPH_LOWER_HALF);
				a = {a[3:0], a[7:4]};
			end
			if (mode_reg[FLAG_HALF_MED]) begin
				c = GLYPH_MEDIUM;
			end
		end else if (ch >= GLYPH_LIGHT && ch <= GLYPH_DARK) begin
			// shades flip on a bright background or a brighter background
			if (a[7] || lum(bg) > lum(fg)) begin
				if (c == GLYPH_LIGHT) begin
					c = GLYPH_DARK;
				end else if (c == GLYPH_DARK) begin
					c = GLYPH_LIGHT;
				end
				a = {a[3:0], a[7:4]};
				if (a[7] && mode_reg[FLAG_BRIGHT_MED] && c == GLYPH_LIGHT) begin
					c = GLYPH_MEDIUM;
				end
			end
		end
		// dark shade and full block removed on request, colors swapped to match
		if ((c == GLYPH_DARK || c == GLYPH_FULL) && mode_reg[FLAG_DROP_DARK]) begin
			c = (c == GLYPH_DARK) ? GLYPH_LIGHT : GLYPH_SPACE;
			a = {a[3:0], a[7:4]};
		end
		r.chr = font_tbl[c];
		r.attr = colour_tbl[a];
		return r;
	endfunction

	// pick a half block or shade for an upper/lower color pair, then render it
	function automatic cell_t render_raster(input logic [7:0] up, input logic [7:0] dn);
		int uw;
		int dw;
		logic [7:0] ch;
		logic [7:0] at;
		uw = pair_weight(up);
		dw = pair_weight(dn);
		ch = GLYPH_LIGHT;
		at = up | dn;
		// two black pixels give equal zero weights and land on the upper half
		if (uw >= 2 * dw) begin
			ch = GLYPH_UPPER_HALF;
			at = {dn[7:4], up[7:4]};
		end else if (dw >= 2 * uw) begin
			ch = GLYPH_LOWER_HALF;
			at = {up[7:4], dn[7:4]};
		end
		return render_cell(ch, at);
	endfunction

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------

	// every field random, so fields an opcode ignores carry noise
	function automatic stim_t noisy_item(input op_t op);
		stim_t s;
		s.is_mode = 1'b0;
		s.mode = 4'($urandom);
		s.op = op;
		s.chr = 8'($urandom);
		s.attr = 8'($urandom);
		s.upper = 8'($urandom);
		s.lower = 8'($urandom);
		s.idx = 8'($urandom);
		s.val = 8'($urandom);
		return s;
	endfunction

	function automatic void add_cell(input logic [7:0] ch, input logic [7:0] at);
		stim_t s;
		s = noisy_item(OP_CELL);
		s.chr = ch;
		s.attr = at;
		stim_q.push_back(s);
	endfunction

	function automatic void add_raster(input logic [7:0] up, input logic [7:0] dn);
		stim_t s;
		s = noisy_item(OP_RASTER);
		s.upper = up;
		s.lower = dn;
		stim_q.push_back(s);
	endfunction

	function automatic void add_load(input op_t op, input logic [7:0] i, input logic [7:0] v);
		stim_t s;
		s = noisy_item(op);
		s.idx = i;
		s.val = v;
		stim_q.push_back(s);
	endfunction

	function automatic void add_mode(input logic [3:0] m);
		stim_t s;
		s = noisy_item(OP_CELL);
		s.is_mode = 1'b1;
		s.mode = m;
		stim_q.push_back(s);
	endfunction

	// random item, biased toward the glyphs and colors with special handling
	function automatic void add_random();
		int r;
		logic [7:0] ch;
		logic [7:0] at;
		logic [7:0] up;
		logic [7:0] dn;
		logic [3:0] n;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			ch = 8'($urandom);
			if ($urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 10))
					0: ch = GLYPH_NUL;
					1: ch = GLYPH_SPACE;
					2: ch = GLYPH_BLANK;
					3: ch = GLYPH_LIGHT;
					4: ch = GLYPH_MEDIUM;
					5: ch = GLYPH_DARK;
					6: ch = GLYPH_FULL;
					7: ch = GLYPH_LOWER_HALF;
					8: ch = GLYPH_LOWER_HALF + 8'd1;
					9: ch = GLYPH_UPPER_HALF - 8'd1;
					default: ch = GLYPH_UPPER_HALF;
				endcase
			end
			at = 8'($urandom);
			if ($urandom_range(0, 7) == 0) begin
				n = 4'($urandom);
				at = {n, n};
			end
			add_cell(ch, at);
		end else if (r < 85) begin
			up = 8'($urandom);
			dn = 8'($urandom);
			case ($urandom_range(0, 7))
				0: begin
					up = 8'd0;
					dn = 8'd0;
				end
				1: dn = up;
				default: ;
			endcase
			add_raster(up, dn);
		end else if (r < 92) begin
			// font loads mostly hit the glyphs the normalizer produces
			ch = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(176, 223)) : 8'($urandom);
			add_load(OP_FONT, ch, ($urandom_range(0, 2) == 0) ? ch : 8'($urandom));
		end else begin
			at = 8'($urandom);
			add_load(OP_COLOUR, at, ($urandom_range(0, 2) == 0) ? at : 8'($urandom));
		end
	endfunction

	// idle length: mostly none or short, now and then long, none in calm stretches
	function automatic int draw_gap();
		int r;
		if ((n_accepted / 128) % 4 == 3) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 98) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic void flag_error(input string what);
		errors++;
		if (errors <= MAX_SHOWN) begin
			$display("mismatch %0d at %0t: %s", errors, $realtime, what);
		end
	endfunction

	// ---------------------------------------------------------------
	// driver: command and mode register channels, changed at the falling edge
	// ---------------------------------------------------------------

	always @(negedge clk) begin : drive_cmd
		stim_t nxt;
		if (arst_n) begin
			if (cmd_ch.valid && !cmd_taken) begin
				// item still offered, hold it
			end else if (cfg_ch.valid && !cfg_taken) begin
				// register write still offered, hold it
			end else if (cmd_gap > 0) begin
				cmd_gap--;
				cmd_ch.valid <= 1'b0;
				cfg_ch.valid <= 1'b0;
			end else if (stim_q.size() == 0) begin
				cmd_ch.valid <= 1'b0;
				cfg_ch.valid <= 1'b0;
			end else if (stim_q[0].is_mode) begin
				// mode writes only once all results are in and loads have drained
				cmd_ch.valid <= 1'b0;
				if (cells_due.size() == 0 && idle_cycles >= SETTLE) begin
					nxt = stim_q.pop_front();
					cfg_ch.valid <= 1'b1;
					cfg_ch.mode_flags <= nxt.mode;
				end else begin
					cfg_ch.valid <= 1'b0;
				end
			end else begin
				nxt = stim_q.pop_front();
				cfg_ch.valid <= 1'b0;
				cmd_ch.valid <= 1'b1;
				cmd_ch.opcode <= nxt.op;
				cmd_ch.cell_char <= nxt.chr;
				cmd_ch.cell_attr <= nxt.attr;
				cmd_ch.raster_upper <= nxt.upper;
				cmd_ch.raster_lower <= nxt.lower;
				cmd_ch.table_index <= nxt.idx;
				cmd_ch.table_value <= nxt.val;
				cmd_gap = draw_gap();
			end
		end
	end

	// result back-pressure, stalls start at random points
	always @(negedge clk) begin : drive_ready
		if (arst_n) begin
			if (res_gap > 0) begin
				res_gap--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0) begin
					res_gap = draw_gap();
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// monitor: handshakes sampled at the rising edge
	// ---------------------------------------------------------------

	always @(posedge clk) begin : observe
		cell_t want;
		bit res_fire;
		cmd_taken = cmd_ch.valid && cmd_ch.ready;
		cfg_taken = cfg_ch.valid && cfg_ch.ready;
		res_fire = res_ch.valid && res_ch.ready;
		if (arst_n) begin
			// check the oldest outstanding cell first
			if (res_fire) begin
				if (cells_due.size() == 0) begin
					flag_error($sformatf("unexpected result char %0d attr 0x%02h",
						res_ch.out_char, res_ch.out_attr));
				end else begin
					want = cells_due.pop_front();
					n_checked++;
					if (res_ch.out_char !== want.chr || res_ch.out_attr !== want.attr) begin
						flag_error($sformatf("char %0d attr 0x%02h, expected char %0d attr 0x%02h",
							res_ch.out_char, res_ch.out_attr, want.chr, want.attr));
					end
				end
			end
			if (cfg_taken) begin
				mode_reg = cfg_ch.mode_flags;
				n_modes++;
			end
			if (cmd_taken) begin
				n_accepted++;
				case (op_t'(cmd_ch.opcode))
					OP_CELL: begin
						cells_due.push_back(render_cell(cmd_ch.cell_char, cmd_ch.cell_attr));
						n_cells++;
					end
					OP_RASTER: begin
						cells_due.push_back(render_raster(cmd_ch.raster_upper,
							cmd_ch.raster_lower));
						n_rasters++;
					end
					OP_FONT: begin
						font_tbl[cmd_ch.table_index] = cmd_ch.table_value;
						n_loads++;
					end
					default: begin
						colour_tbl[cmd_ch.table_index] = cmd_ch.table_value;
						n_loads++;
					end
				endcase
			end
			// count quiet cycles so mode writes wait for in-flight loads
			if (cmd_taken || res_fire || cells_due.size() != 0) begin
				idle_cycles = 0;
			end else if (idle_cycles < 1000) begin
				idle_cycles++;
			end
		end
	end

	// ---------------------------------------------------------------
	// sequence of the run
	// ---------------------------------------------------------------

	initial begin : run
		int ph;
		int k;
		logic [3:0] phase_modes [8];
		// known levels on every input from time zero
		clk = 1'b0;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.opcode = OP_CELL;
		cmd_ch.cell_char = 8'd0;
		cmd_ch.cell_attr = 8'd0;
		cmd_ch.raster_upper = 8'd0;
		cmd_ch.raster_lower = 8'd0;
		cmd_ch.table_index = 8'd0;
		cmd_ch.table_value = 8'd0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.mode_flags = 4'd0;
		for (k = 0; k < 256; k++) begin
			font_tbl[k] = 8'(k);
			colour_tbl[k] = 8'(k);
		end
		mode_reg = MODE_RESET;

		// directed cells under the reset mode
		add_cell(GLYPH_NUL, 8'h00);                // dark blank
		add_cell(GLYPH_SPACE, 8'h8f);              // space on a bright background
		add_cell(GLYPH_BLANK, 8'hff);
		add_cell(GLYPH_FULL, 8'h12);               // full block takes its foreground
		add_cell(8'd65, 8'h99);                    // same bright colors
		add_cell(8'd65, 8'h1e);
		add_cell(GLYPH_LIGHT, 8'h8e);              // light shade, bright background
		add_cell(GLYPH_DARK, 8'h87);
		add_cell(GLYPH_DARK, 8'h9e);               // flips with a bright background, shown as medium under the reset mode
		add_cell(GLYPH_MEDIUM, 8'h27);             // brighter foreground, kept
		add_cell(GLYPH_MEDIUM, 8'h72);             // brighter background, flipped
		add_cell(GLYPH_LOWER_HALF, 8'he1);         // half block flipped
		add_cell(GLYPH_UPPER_HALF, 8'h61);         // dark background, kept
		add_cell(GLYPH_LOWER_HALF + 8'd1, 8'h1e);
		// directed raster pairs
		add_raster(8'h00, 8'h00);                  // both black
		add_raster(8'hff, 8'h00);                  // upper dominates
		add_raster(8'h00, 8'hf7);                  // lower dominates
		add_raster(8'h27, 8'h72);                  // close weights, same mixed color
		add_raster(8'h21, 8'h43);                  // close weights, shade
		add_raster(8'hff, 8'hff);
		// map loads, then a cell that reads both new entries
		add_load(OP_FONT, 8'd65, 8'h5a);
		add_load(OP_COLOUR, 8'h1e, 8'hc3);
		add_cell(8'd65, 8'h1e);
		add_load(OP_FONT, 8'd65, 8'd65);

		// random phases, each under its own mode setting, extremes first
		phase_modes[0] = 4'd15;
		phase_modes[1] = 4'd0;
		phase_modes[2] = 4'd1;
		phase_modes[3] = 4'd2;
		phase_modes[4] = MODE_RESET;
		phase_modes[5] = 4'd11;
		phase_modes[6] = 4'($urandom);
		phase_modes[7] = 4'($urandom);
		for (ph = 0; ph < 8; ph++) begin
			add_mode(phase_modes[ph]);
			for (k = 0; k < PHASE_ITEMS; k++) begin
				add_random();
			end
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// drain: everything sent and every cell returned
		while (stim_q.size() != 0 || cmd_ch.valid || cfg_ch.valid || cells_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (4 * SETTLE) @(posedge clk);
		if (cells_due.size() != 0) begin
			flag_error($sformatf("%0d results never arrived", cells_due.size()));
		end

		$display("covered %0d items: %0d cells, %0d raster pairs, %0d map loads, %0d mode writes",
			n_accepted, n_cells, n_rasters, n_loads, n_modes);
		$display("%0d results checked, %0d mismatches", n_checked, errors);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// hard stop far beyond the slowest correct run
	initial begin : watchdog
		#3000000;
		$display("timeout with %0d items unsent and %0d results outstanding",
			stim_q.size(), cells_due.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/tcr_pkg.sv
rtl/tcr_if.sv
rtl/tcr_raster.sv
rtl/tcr_norm.sv
rtl/tcr_map.sv
rtl/text_cell_renderer.sv
sim/testbench.sv
